### rtl/core/ffca_pkg.sv
// Shared types and constants of the first-fit chunk allocator.
package ffca_pkg;

  localparam int WORD_W  = 15;
  localparam int CHUNK_W = 10;
  localparam int COUNT_W = 11;

  localparam int DEF_MAP_ENTRIES = 1024;
  localparam int DEF_CHUNK_WORDS = 27;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] MARK_FREE  = 2'd0;
  localparam logic [1:0] MARK_BEGIN = 2'd1;
  localparam logic [1:0] MARK_CONT  = 2'd2;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NOSPACE    = 2'd1;
  localparam logic [1:0] ST_MISALIGNED = 2'd2;
  localparam logic [1:0] ST_NOTSTART   = 2'd3;

  typedef struct packed {
    logic              opcode;
    logic [WORD_W-1:0] request_words;
    logic [WORD_W-1:0] free_offset;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [CHUNK_W-1:0] start_chunk;
    logic [WORD_W-1:0]  word_offset;
    logic [COUNT_W-1:0] chunk_count;
  } rsp_t;

endpackage

### rtl/core/first_fit_chunk_allocator.sv
// First-fit chunk allocator: chunk map, reciprocal divider and scan sequencer.
//
// Request beats (req, req_valid, req_stall) carry an allocate or a free.
// Response beats (rsp, rsp_valid, rsp_stall) carry one result per request.
// A beat moves at a rising edge with valid high and stall low.
// After reset the block clears the map one entry a cycle
// and holds req_stall high until the pass is done.
// Each request first divides by CHUNK_WORDS with one reciprocal multiply.
// Allocate then scans the map through its single read port, one entry a cycle,
// and writes one mark a cycle for the block.
// Free reads and clears one entry at a time, through S_FRD and S_FCHK,
// until a non-continuation or the map end.
// The next request beat can be taken from the cycle after the response is loaded.
// One request is in progress at a time; req_stall is low only when idle.
// The response sits in an output register; a stalled response holds there
// while the next request is taken, and a new one waits until it moves.
module first_fit_chunk_allocator
  import ffca_pkg::*;
#(
  parameter int MAP_ENTRIES = DEF_MAP_ENTRIES,
  parameter int CHUNK_WORDS = DEF_CHUNK_WORDS
) (
  input  logic clk,
  input  logic rst,
  input  req_t req,
  input  logic req_valid,
  output logic req_stall,
  output rsp_t rsp,
  output logic rsp_valid,
  input  logic rsp_stall
);

  localparam int IDX_W  = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(MAP_ENTRIES + 1);
  localparam int NEED_W = WORD_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAP_ENTRIES - 1);
  localparam int RECIP_SHIFT = 27;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int QPROD_W     = WORD_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(CHUNK_WORDS) - 64'd1) / 64'(CHUNK_WORDS));

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIV, S_DECIDE, S_SCAN, S_MARK, S_FRD, S_FCHK, S_RESP
  } state_t;

  state_t            state;
  logic [1:0]        mem [MAP_ENTRIES];
  logic [1:0]        rdata;
  logic [IDX_W-1:0]  raddr;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [1:0]        wdata;

  logic [IDX_W-1:0]  clr_idx;
  logic              op;
  logic [WORD_W-1:0] dvd;
  logic [WORD_W-1:0] orig;
  logic [NEED_W-1:0] need;
  logic [CNT_W-1:0]  run;
  logic [IDX_W-1:0]  scan_idx;
  logic              pend;
  logic [IDX_W-1:0]  pend_idx;
  logic [IDX_W-1:0]  mark_idx;
  logic [CNT_W-1:0]  mark_left;
  logic [IDX_W-1:0]  fidx;
  logic              first;
  logic [1:0]        res_st;
  logic              res_ok;
  logic [IDX_W-1:0]  res_chunk;
  logic [CNT_W-1:0]  res_cnt;

  logic [QPROD_W-1:0] qprod;
  logic [CNT_W-1:0]  need_c;
  logic [CNT_W-1:0]  run_next;
  logic [IDX_W-1:0]  start;
  logic              fclear;
  logic [31:0]       chunk_ext;
  logic [31:0]       cnt_ext;
  logic [31:0]       prod;
  logic              rsp_load;
  rsp_t              rsp_next;

  assign req_stall = (state != S_IDLE);

  assign qprod = QPROD_W'(dvd) * QPROD_W'(RECIP);

  assign need_c   = CNT_W'(need);
  assign run_next = (rdata == MARK_FREE) ? run + CNT_W'(1) : '0;
  assign start    = IDX_W'(CNT_W'(pend_idx) + CNT_W'(1) - need_c);
  assign fclear   = first || (rdata == MARK_CONT);

  assign chunk_ext = 32'(res_chunk);
  assign cnt_ext   = 32'(res_cnt);
  assign prod      = chunk_ext * 32'(CHUNK_WORDS);

  assign rsp_load = (state == S_RESP) && (!rsp_valid || !rsp_stall);

  always_comb begin
    rsp_next.status      = res_st;
    rsp_next.start_chunk = '0;
    rsp_next.word_offset = '0;
    rsp_next.chunk_count = '0;
    if (res_ok) begin
      rsp_next.start_chunk = chunk_ext[CHUNK_W-1:0];
      rsp_next.word_offset = prod[WORD_W-1:0];
      rsp_next.chunk_count = cnt_ext[COUNT_W-1:0];
    end
  end

  always_comb begin
    raddr = (state == S_SCAN) ? scan_idx : fidx;
    we    = 1'b0;
    waddr = fidx;
    wdata = MARK_FREE;
    case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_idx;
      end
      S_MARK: begin
        we    = 1'b1;
        waddr = mark_idx;
        wdata = (mark_idx == res_chunk) ? MARK_BEGIN : MARK_CONT;
      end
      S_FCHK: begin
        we = fclear;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      rsp_valid <= 1'b0;
      pend      <= 1'b0;
      first     <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + IDX_W'(1);
          if (clr_idx == LAST_IDX) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            op    <= req.opcode;
            dvd   <= (req.opcode == OP_FREE) ? req.free_offset : req.request_words;
            orig  <= (req.opcode == OP_FREE) ? req.free_offset : req.request_words;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          dvd   <= qprod[RECIP_SHIFT +: WORD_W];
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          res_cnt <= '0;
          if (op == OP_ALLOC) begin
            need <= NEED_W'(dvd) + NEED_W'(1);
            if (32'(dvd) + 32'd1 > 32'(MAP_ENTRIES)) begin
              res_st <= ST_NOSPACE;
              res_ok <= 1'b0;
              state  <= S_RESP;
            end else begin
              run      <= '0;
              scan_idx <= '0;
              pend     <= 1'b0;
              state    <= S_SCAN;
            end
          end else begin
            if (32'(dvd) >= 32'(MAP_ENTRIES)) begin
              res_st <= ST_NOTSTART;
              res_ok <= 1'b0;
              state  <= S_RESP;
            end else begin
              fidx      <= IDX_W'(dvd);
              res_chunk <= IDX_W'(dvd);
              first     <= 1'b1;
              state     <= S_FRD;
            end
          end
        end
        S_SCAN: begin
          pend_idx <= scan_idx;
          scan_idx <= scan_idx + IDX_W'(1);
          if (pend && run_next == need_c) begin
            res_chunk <= start;
            res_cnt   <= need_c;
            mark_idx  <= start;
            mark_left <= need_c;
            res_st    <= ST_OK;
            res_ok    <= 1'b1;
            pend      <= 1'b0;
            state     <= S_MARK;
          end else if (pend && pend_idx == LAST_IDX) begin
            res_st <= ST_NOSPACE;
            res_ok <= 1'b0;
            pend   <= 1'b0;
            state  <= S_RESP;
          end else begin
            pend <= 1'b1;
            if (pend) begin
              run <= run_next;
            end
          end
        end
        S_MARK: begin
          mark_idx  <= mark_idx + IDX_W'(1);
          mark_left <= mark_left - CNT_W'(1);
          if (mark_left == CNT_W'(1)) begin
            state <= S_RESP;
          end
        end
        S_FRD: begin
          state <= S_FCHK;
        end
        S_FCHK: begin
          if (fclear) begin
            first   <= 1'b0;
            res_cnt <= res_cnt + CNT_W'(1);
            if (first) begin
              res_ok <= 1'b1;
              if (prod != 32'(orig)) begin
                res_st <= ST_MISALIGNED;
              end else if (rdata != MARK_BEGIN) begin
                res_st <= ST_NOTSTART;
              end else begin
                res_st <= ST_OK;
              end
            end
            if (fidx == LAST_IDX) begin
              state <= S_RESP;
            end else begin
              fidx  <= fidx + IDX_W'(1);
              state <= S_FRD;
            end
          end else begin
            state <= S_RESP;
          end
        end
        S_RESP: begin
          if (rsp_load) begin
            rsp   <= rsp_next;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_accept_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && req_valid) |=> (state == S_DIV))
    else $error("accepted request did not start the divide");

  a_mark_left: assert property (@(posedge clk) disable iff (rst)
    (state == S_MARK) |-> (mark_left != '0))
    else $error("mark pass entered with nothing to mark");

  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (run < need_c))
    else $error("free run passed the request size");

  a_nospace_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == ST_NOSPACE) |->
      (rsp.start_chunk == '0 && rsp.chunk_count == '0 && rsp.word_offset == '0))
    else $error("no-space response carries a block");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP && rsp_valid && rsp_stall) |=> (state == S_RESP))
    else $error("response overwrote a stalled beat");

endmodule

### bench/first_fit_chunk_allocator_tb.sv
// Self-checking bench for the first-fit chunk allocator: directed and random beats.
module first_fit_chunk_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ffca_pkg::*;

  localparam int MAP_SIZE     = DEF_MAP_ENTRIES;
  localparam int CHUNK_SIZE   = DEF_CHUNK_WORDS;
  localparam int POOL_WORDS   = MAP_SIZE * CHUNK_SIZE;
  localparam int RANDOM_BEATS = 270;
  localparam int IDLE_LIMIT   = 20000;
  localparam int DRAIN_CYCLES = 2 * MAP_SIZE + 60;

  class chunk_ledger;
    logic [1:0]  marks [MAP_SIZE];
    rsp_t        owed [$];
    int unsigned errors;

    function new();
      foreach (marks[i]) marks[i] = MARK_FREE;
      errors = 0;
    endfunction

    function void note_request(req_t r);
      rsp_t res;
      int   need, run, first, chunk, count, idx;
      res = '0;
      if (r.opcode == OP_ALLOC) begin
        need = int'(r.request_words) / CHUNK_SIZE + 1;
        res.status = ST_NOSPACE;
        run = 0;
        if (need <= MAP_SIZE) begin
          for (int i = 0; i < MAP_SIZE; i++) begin
            run = (marks[i] == MARK_FREE) ? run + 1 : 0;
            if (run == need) begin
              first = i + 1 - need;
              for (int k = 0; k < need; k++) begin
                marks[first + k] = (k == 0) ? MARK_BEGIN : MARK_CONT;
              end
              res.status      = ST_OK;
              res.start_chunk = CHUNK_W'(first);
              res.word_offset = WORD_W'(first * CHUNK_SIZE);
              res.chunk_count = COUNT_W'(need);
              break;
            end
          end
        end
      end else begin
        chunk = int'(r.free_offset) / CHUNK_SIZE;
        if (chunk >= MAP_SIZE) begin
          res.status = ST_NOTSTART;
        end else begin
          if (int'(r.free_offset) % CHUNK_SIZE != 0) begin
            res.status = ST_MISALIGNED;
          end else if (marks[chunk] != MARK_BEGIN) begin
            res.status = ST_NOTSTART;
          end else begin
            res.status = ST_OK;
          end
          marks[chunk] = MARK_FREE;
          count = 1;
          idx = chunk + 1;
          while (idx < MAP_SIZE && marks[idx] == MARK_CONT) begin
            marks[idx] = MARK_FREE;
            idx++;
            count++;
          end
          res.start_chunk = CHUNK_W'(chunk);
          res.word_offset = WORD_W'(chunk * CHUNK_SIZE);
          res.chunk_count = COUNT_W'(count);
        end
      end
      owed.push_back(res);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (owed.size() == 0) begin
        $error("response beat with nothing outstanding: %p", got);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.start_chunk !== want.start_chunk) begin
        $error("start_chunk: expected %0d, actual %0d", want.start_chunk, got.start_chunk);
        errors++;
      end
      if (got.word_offset !== want.word_offset) begin
        $error("word_offset: expected %0d, actual %0d", want.word_offset, got.word_offset);
        errors++;
      end
      if (got.chunk_count !== want.chunk_count) begin
        $error("chunk_count: expected %0d, actual %0d", want.chunk_count, got.chunk_count);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  req_t req;
  logic req_valid;
  logic req_stall;
  rsp_t rsp;
  logic rsp_valid;
  logic rsp_stall;

  chunk_ledger ledger;
  int unsigned beats_sent;
  int unsigned stall_left;
  int unsigned cycle_count;
  int unsigned idle_cycles;

  first_fit_chunk_allocator uut (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall)
  );

  always #6 clk = ~clk;

  function automatic int unsigned idle_span();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 200);
  endfunction

  function automatic req_t alloc_req(int words);
    req_t r;
    r = req_t'({$urandom, $urandom});
    r.opcode = OP_ALLOC;
    r.request_words = WORD_W'(words);
    return r;
  endfunction

  function automatic req_t free_req(int offset);
    req_t r;
    r = req_t'({$urandom, $urandom});
    r.opcode = OP_FREE;
    r.free_offset = WORD_W'(offset);
    return r;
  endfunction

  function automatic req_t next_request();
    int starts [$];
    int pick, roll, free_share;
    foreach (ledger.marks[i]) begin
      if (ledger.marks[i] == MARK_BEGIN) starts.push_back(i);
    end
    free_share = (starts.size() > 12) ? 60 : 40;
    roll = $urandom_range(0, 99);
    if (starts.size() != 0 && roll < free_share) begin
      pick = starts[$urandom_range(0, starts.size() - 1)];
      roll = $urandom_range(0, 99);
      if (roll < 70) return free_req(pick * CHUNK_SIZE);
      if (roll < 82) return free_req(pick * CHUNK_SIZE + $urandom_range(1, CHUNK_SIZE - 1));
      if (roll < 94) return free_req($urandom_range(0, POOL_WORDS - 1));
      return free_req($urandom_range(POOL_WORDS, 32767));
    end
    roll = $urandom_range(0, 99);
    if (roll < 75) return alloc_req($urandom_range(0, 8 * CHUNK_SIZE));
    if (roll < 93) return alloc_req($urandom_range(0, 64 * CHUNK_SIZE));
    if (roll < 97) return alloc_req($urandom_range(0, 32767));
    return alloc_req($urandom_range(POOL_WORDS - 300, POOL_WORDS - 1));
  endfunction

  task automatic send_request(input req_t r);
    int unsigned gap;
    gap = (beats_sent % 60 < 12) ? 0 : idle_span();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    ledger.note_request(r);
    beats_sent++;
  endtask

  // sample the result beat, then choose the stall for the next cycle
  always @(posedge clk) begin
    cycle_count++;
    if (!rst && rsp_valid && !rsp_stall) ledger.check_response(rsp);
    if (stall_left != 0) begin
      stall_left--;
      rsp_stall <= 1'b1;
    end else if ((cycle_count / 500) % 4 != 0 && $urandom_range(0, 99) < 30) begin
      stall_left = idle_span();
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("first_fit_chunk_allocator_tb failed");
      $finish;
    end
  end

  initial begin
    req_t opening [$];
    ledger = new();
    beats_sent = 0;
    stall_left = 0;
    cycle_count = 0;
    idle_cycles = 0;
    rst <= 1'b1;
    req <= '0;
    req_valid <= 1'b0;
    rsp_stall <= 1'b0;

    opening.push_back(alloc_req(0));
    opening.push_back(alloc_req(CHUNK_SIZE - 1));
    opening.push_back(alloc_req(CHUNK_SIZE));
    opening.push_back(alloc_req(32767));
    opening.push_back(alloc_req(POOL_WORDS - 1));
    opening.push_back(free_req(CHUNK_SIZE));
    opening.push_back(free_req(CHUNK_SIZE));
    opening.push_back(free_req(2 * CHUNK_SIZE + 1));
    opening.push_back(alloc_req(2 * CHUNK_SIZE - 1));
    opening.push_back(free_req(2 * CHUNK_SIZE));
    opening.push_back(free_req(POOL_WORDS));
    opening.push_back(free_req(32767));
    opening.push_back(free_req(0));
    opening.push_back(free_req(CHUNK_SIZE));
    opening.push_back(alloc_req(POOL_WORDS - 1));
    opening.push_back(alloc_req(0));
    opening.push_back(free_req(POOL_WORDS - CHUNK_SIZE));
    opening.push_back(free_req(CHUNK_SIZE - 1));
    opening.push_back(alloc_req(POOL_WORDS - CHUNK_SIZE - 1));
    opening.push_back(alloc_req(0));
    opening.push_back(alloc_req(0));
    opening.push_back(free_req(POOL_WORDS - CHUNK_SIZE));
    opening.push_back(free_req(0));
    opening.push_back(free_req(POOL_WORDS - 1));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (opening[i]) send_request(opening[i]);
    for (int n = 0; n < RANDOM_BEATS; n++) send_request(next_request());
    req_valid <= 1'b0;

    while (ledger.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (ledger.errors == 0) begin
      $display("first_fit_chunk_allocator_tb passed");
    end else begin
      $display("first_fit_chunk_allocator_tb failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/ffca_pkg.sv
rtl/core/first_fit_chunk_allocator.sv
bench/first_fit_chunk_allocator_tb.sv
